// ----- hdl/mme_pkg.sv -----
package mme_pkg;

	// Field widths of the item and result words.
	localparam int IDX_W = 6;
	localparam int VAL_W = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int PV_W = 38;

	// Configuration register file.
	localparam int CFG_W = 7;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd2;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Kind codes on the input channel.
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_REQUEST = 2'd2;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;

	// Operations that survive classification.
	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_REQUEST = 2'd2
	} op_t;

	// One classified word waiting for the back part.
	typedef struct packed {
		op_t op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} entry_t;

	// Sequencer of the back part.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} back_state_t;

endpackage

// ----- hdl/mme_ram.sv -----
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/mme_front.sv -----
module mme_front #(
	parameter int DIM_MAX = 64,
	parameter int LW = 7
) (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [mme_pkg::IDX_W-1:0]     row_index,
	input  logic [mme_pkg::IDX_W-1:0]     col_index,
	input  logic [mme_pkg::VAL_W-1:0]     element_value,
	input  logic [mme_pkg::CFG_W-1:0]     rows_a,
	input  logic [mme_pkg::CFG_W-1:0]     inner_len,
	input  logic [mme_pkg::CFG_W-1:0]     cols_b,
	input  logic                          q_full,
	output logic                          push,
	output mme_pkg::entry_t               push_entry,
	output logic [LW-1:0]                 k_len
);

	logic [LW-1:0] m_len;
	logic [LW-1:0] n_len;
	logic          row_lt_m;
	logic          row_lt_k;
	logic          col_lt_k;
	logic          col_lt_n;
	logic          keep;
	logic          accept;

	// Register values above the store size act as the store size.
	assign m_len = (32'(rows_a) > DIM_MAX) ? LW'(DIM_MAX) : LW'(rows_a);
	assign k_len = (32'(inner_len) > DIM_MAX) ? LW'(DIM_MAX) : LW'(inner_len);
	assign n_len = (32'(cols_b) > DIM_MAX) ? LW'(DIM_MAX) : LW'(cols_b);

	assign row_lt_m = 32'(row_index) < 32'(m_len);
	assign row_lt_k = 32'(row_index) < 32'(k_len);
	assign col_lt_k = 32'(col_index) < 32'(k_len);
	assign col_lt_n = 32'(col_index) < 32'(n_len);

	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;

	// Classify the word and drop anything out of range or of unused kind.
	always_comb begin
		keep = 1'b0;
		push_entry.op = mme_pkg::OP_REQUEST;
		unique case (kind)
			mme_pkg::KIND_LOAD_A: begin
				keep = row_lt_m && col_lt_k;
				push_entry.op = mme_pkg::OP_LOAD_A;
			end
			mme_pkg::KIND_LOAD_B: begin
				keep = row_lt_k && col_lt_n;
				push_entry.op = mme_pkg::OP_LOAD_B;
			end
			mme_pkg::KIND_REQUEST: begin
				keep = row_lt_m && col_lt_n;
				push_entry.op = mme_pkg::OP_REQUEST;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		push_entry.row = row_index;
		push_entry.col = col_index;
		push_entry.value = element_value;
	end

	assign push = accept && keep;

endmodule

// ----- hdl/mme_queue.sv -----
module mme_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mme_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output mme_pkg::entry_t head
);

	localparam int PW = (mme_pkg::QUEUE_DEPTH > 1) ? $clog2(mme_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(mme_pkg::QUEUE_DEPTH + 1);

	mme_pkg::entry_t slot_q [mme_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full = (32'(count_q) == mme_pkg::QUEUE_DEPTH);
	assign not_empty = (count_q != '0);
	assign head = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;

	// Storage slots; payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == mme_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == mme_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/mme_back.sv -----
module mme_back #(
	parameter int DIM_MAX = 64,
	parameter int LW = 7,
	parameter int AW = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_not_empty,
	input  mme_pkg::entry_t                head,
	output logic                           pop,
	input  logic [LW-1:0]                  k_len,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mme_pkg::IDX_W-1:0]      out_row,
	output logic [mme_pkg::IDX_W-1:0]      out_col,
	output logic signed [mme_pkg::PV_W-1:0] product_value
);

	localparam int DEPTH = DIM_MAX * DIM_MAX;

	mme_pkg::back_state_t state_q;
	mme_pkg::back_state_t state_d;

	logic [mme_pkg::IDX_W-1:0]         row_q;
	logic [mme_pkg::IDX_W-1:0]         col_q;
	logic [AW-1:0]                     a_addr_q;
	logic [AW-1:0]                     b_addr_q;
	logic [LW-1:0]                     cnt_q;
	logic signed [mme_pkg::PV_W-1:0]   acc_q;
	logic [AW-1:0]                     waddr;
	logic                              we_a;
	logic                              we_b;
	logic                              start_req;
	logic                              issue;
	logic                              issue_last;
	logic                              load_out;
	logic [mme_pkg::VAL_W-1:0]         a_rd;
	logic [mme_pkg::VAL_W-1:0]         b_rd;
	logic                              rd_v_s1;
	logic                              rd_last_s1;
	logic signed [mme_pkg::PROD_W-1:0] prod_s2;
	logic                              prod_v_s2;
	logic                              prod_last_s2;
	logic                              out_valid_q;

	// Element (r,c) lives at r*DIM_MAX+c in both stores.
	assign waddr = AW'(32'(head.row) * DIM_MAX + 32'(head.col));

	mme_ram #(
		.WIDTH(mme_pkg::VAL_W),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_a_store (
		.clk(clk),
		.we(we_a),
		.waddr(waddr),
		.wdata(head.value),
		.raddr(a_addr_q),
		.rdata(a_rd)
	);

	mme_ram #(
		.WIDTH(mme_pkg::VAL_W),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_b_store (
		.clk(clk),
		.we(we_b),
		.waddr(waddr),
		.wdata(head.value),
		.raddr(b_addr_q),
		.rdata(b_rd)
	);

	// Sequencer outputs.
	always_comb begin
		pop = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				pop = q_not_empty;
			end
			mme_pkg::ST_WALK: begin
				issue = 1'b1;
			end
			mme_pkg::ST_DRAIN: begin
				issue = 1'b0;
			end
			mme_pkg::ST_DONE: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign we_a = pop && (head.op == mme_pkg::OP_LOAD_A);
	assign we_b = pop && (head.op == mme_pkg::OP_LOAD_B);
	assign start_req = pop && (head.op == mme_pkg::OP_REQUEST);
	assign issue_last = issue && (cnt_q == k_len - LW'(1));

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				if (start_req) begin
					state_d = (k_len == '0) ? mme_pkg::ST_DONE : mme_pkg::ST_WALK;
				end
			end
			mme_pkg::ST_WALK: begin
				if (issue_last) begin
					state_d = mme_pkg::ST_DRAIN;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (prod_last_s2) begin
					state_d = mme_pkg::ST_DONE;
				end
			end
			mme_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = mme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers of the walk pipeline and the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			rd_v_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			prod_last_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			rd_last_s1 <= issue_last;
			prod_v_s2 <= rd_v_s1;
			prod_last_s2 <= rd_last_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk addresses: A steps along a row, B steps down a column.
	always_ff @(posedge clk) begin
		if (start_req) begin
			row_q <= head.row;
			col_q <= head.col;
			a_addr_q <= AW'(32'(head.row) * DIM_MAX);
			b_addr_q <= AW'(head.col);
			cnt_q <= '0;
		end else if (issue) begin
			a_addr_q <= a_addr_q + AW'(1);
			b_addr_q <= b_addr_q + AW'(DIM_MAX);
			cnt_q <= cnt_q + LW'(1);
		end
	end

	// Multiply stage, then accumulate at full width.
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rd) * $signed(b_rd);
		if (start_req) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + mme_pkg::PV_W'(prod_s2);
		end
	end

	// Output word, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row <= row_q;
			out_col <= col_q;
			product_value <= acc_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/matrix_multiply_engine.sv -----
// Matrix product engine, fixed point Q8.8 elements, Q22.16 results.
// Input channel (in_valid/in_stall): each word is a load of one element of
// A or B (kind 0 or 1) or a request for one element of C (kind 2). Loads
// with indices outside the configured sizes, requests outside rows_a by
// cols_b, and kind 3 are dropped without a result.
// Output channel (out_valid/out_stall): one word per valid request, in
// request order, carrying the row, the column and the 38-bit dot product.
// Accepted words enter a four-deep queue; the back part takes one entry at a
// time, and a request is served by the single multiply-accumulate that walks
// one element pair per cycle through the store read ports. The input stalls
// only while the queue is full. A finished result waits in the output
// register while out_stall is high; the back part holds its next result
// until that register is free. Reset clears the queue and the sequencer and
// sets all three size registers to 64. Store contents are undefined until
// loaded. The user must write sizes over the APB port only while the engine
// is idle; the block itself does not enforce it.
module matrix_multiply_engine #(
	parameter int DIM_MAX = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mme_pkg::PADDR_W-1:0]     paddr,
	input  logic [mme_pkg::PDATA_W-1:0]     pwdata,
	output logic [mme_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [mme_pkg::IDX_W-1:0]       row_index,
	input  logic [mme_pkg::IDX_W-1:0]       col_index,
	input  logic signed [mme_pkg::VAL_W-1:0] element_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mme_pkg::IDX_W-1:0]       out_row,
	output logic [mme_pkg::IDX_W-1:0]       out_col,
	output logic signed [mme_pkg::PV_W-1:0] product_value
);

	localparam int LW = $clog2(DIM_MAX + 1);
	localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX * DIM_MAX) : 1;

	logic [mme_pkg::CFG_W-1:0]     rows_a_q;
	logic [mme_pkg::CFG_W-1:0]     inner_len_q;
	logic [mme_pkg::CFG_W-1:0]     cols_b_q;
	logic [mme_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;
	logic                          q_full;
	logic                          q_not_empty;
	logic                          push;
	logic                          pop;
	mme_pkg::entry_t               push_entry;
	mme_pkg::entry_t               head;
	logic [LW-1:0]                 k_len;

	// APB register file.
	assign pready = 1'b1;
	assign reg_idx = paddr[mme_pkg::PADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= mme_pkg::CFG_RESET;
			inner_len_q <= mme_pkg::CFG_RESET;
			cols_b_q <= mme_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mme_pkg::REG_ROWS_A: rows_a_q <= pwdata[mme_pkg::CFG_W-1:0];
				mme_pkg::REG_INNER_LEN: inner_len_q <= pwdata[mme_pkg::CFG_W-1:0];
				mme_pkg::REG_COLS_B: cols_b_q <= pwdata[mme_pkg::CFG_W-1:0];
				default: rows_a_q <= rows_a_q;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (reg_idx)
			mme_pkg::REG_ROWS_A: prdata = mme_pkg::PDATA_W'(rows_a_q);
			mme_pkg::REG_INNER_LEN: prdata = mme_pkg::PDATA_W'(inner_len_q);
			mme_pkg::REG_COLS_B: prdata = mme_pkg::PDATA_W'(cols_b_q);
			default: prdata = '0;
		endcase
	end

	mme_front #(
		.DIM_MAX(DIM_MAX),
		.LW(LW)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.row_index(row_index),
		.col_index(col_index),
		.element_value(element_value),
		.rows_a(rows_a_q),
		.inner_len(inner_len_q),
		.cols_b(cols_b_q),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry),
		.k_len(k_len)
	);

	mme_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(pop),
		.not_empty(q_not_empty),
		.head(head)
	);

	mme_back #(
		.DIM_MAX(DIM_MAX),
		.LW(LW),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.head(head),
		.pop(pop),
		.k_len(k_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_row(out_row),
		.out_col(out_col),
		.product_value(product_value)
	);

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int DIM_MAX = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [mme_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// One input word waiting to be driven, and one expected result word.
	typedef struct {
		logic [1:0] kind;
		logic [mme_pkg::IDX_W-1:0] row;
		logic [mme_pkg::IDX_W-1:0] col;
		logic signed [mme_pkg::VAL_W-1:0] value;
		bit hold;
	} word_t;

	typedef struct {
		logic [mme_pkg::IDX_W-1:0] row;
		logic [mme_pkg::IDX_W-1:0] col;
		logic signed [mme_pkg::PV_W-1:0] value;
	} product_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mme_pkg::PADDR_W-1:0] paddr = '0;
	logic [mme_pkg::PDATA_W-1:0] pwdata = '0;
	logic [mme_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [mme_pkg::IDX_W-1:0] row_index = '0;
	logic [mme_pkg::IDX_W-1:0] col_index = '0;
	logic signed [mme_pkg::VAL_W-1:0] element_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [mme_pkg::IDX_W-1:0] out_row;
	logic [mme_pkg::IDX_W-1:0] out_col;
	logic signed [mme_pkg::PV_W-1:0] product_value;

	// Words to drive and products still owed by the engine.
	word_t pending[$];
	product_t product_due[$];

	// Predictor state: element stores and the sizes in use.
	logic signed [mme_pkg::VAL_W-1:0] a_mem [DIM_MAX*DIM_MAX];
	logic signed [mme_pkg::VAL_W-1:0] b_mem [DIM_MAX*DIM_MAX];
	int cfg_rows = int'(mme_pkg::CFG_RESET);
	int cfg_inner = int'(mme_pkg::CFG_RESET);
	int cfg_cols = int'(mme_pkg::CFG_RESET);

	// Stimulus bookkeeping: which store entries hold a loaded value.
	bit a_set [DIM_MAX*DIM_MAX];
	bit b_set [DIM_MAX*DIM_MAX];
	int words_counted = 0;

	word_t cur_word;
	bit word_loaded = 1'b0;
	bit word_taken = 1'b0;
	bit next_valid;
	int in_wait = 0;
	bit result_taken = 1'b0;
	int out_wait = 0;
	int calm_left [2] = '{0, 0};
	int mismatches = 0;
	int cycles = 0;

	matrix_multiply_engine #(
		.DIM_MAX(DIM_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.row_index(row_index),
		.col_index(col_index),
		.element_value(element_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_row(out_row),
		.out_col(out_col),
		.product_value(product_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Wait length for one word on either side, with stretches of no waiting.
	function automatic int draw_wait(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(10, 50);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic int clamp_size(input logic [mme_pkg::CFG_W-1:0] v);
		return (int'(v) > DIM_MAX) ? DIM_MAX : int'(v);
	endfunction

	function automatic int pick_below(input int n);
		return $urandom_range(0, n - 1);
	endfunction

	// Uniform random element value.
	function automatic logic [mme_pkg::VAL_W-1:0] rand_value();
		logic [31:0] raw;
		raw = $urandom;
		return raw[mme_pkg::VAL_W-1:0];
	endfunction

	// Element values lean toward the extremes so that large sums appear.
	function automatic logic [mme_pkg::VAL_W-1:0] draw_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return rand_value();
		endcase
	endfunction

	// Full-width dot product of one row of A with one column of B.
	function automatic logic signed [mme_pkg::PV_W-1:0] dot_product(input int r, input int c);
		longint acc;
		acc = 0;
		for (int i = 0; i < cfg_inner; i++)
			acc += longint'(a_mem[r*DIM_MAX + i]) * longint'(b_mem[i*DIM_MAX + c]);
		return acc[mme_pkg::PV_W-1:0];
	endfunction

	// Update the stores or queue an expected product for one accepted word.
	task automatic apply_word(input logic [1:0] k, input logic [mme_pkg::IDX_W-1:0] r,
			input logic [mme_pkg::IDX_W-1:0] c, input logic signed [mme_pkg::VAL_W-1:0] v);
		product_t res;
		case (k)
			mme_pkg::KIND_LOAD_A: begin
				if (int'(r) < cfg_rows && int'(c) < cfg_inner)
					a_mem[int'(r)*DIM_MAX + int'(c)] = v;
			end
			mme_pkg::KIND_LOAD_B: begin
				if (int'(r) < cfg_inner && int'(c) < cfg_cols)
					b_mem[int'(r)*DIM_MAX + int'(c)] = v;
			end
			mme_pkg::KIND_REQUEST: begin
				if (int'(r) < cfg_rows && int'(c) < cfg_cols) begin
					res.row = r;
					res.col = c;
					res.value = dot_product(int'(r), int'(c));
					product_due.push_back(res);
				end
			end
			default: ;
		endcase
	endtask

	// Register write over APB: setup cycle, then access cycle.
	task automatic apb_write(input logic [mme_pkg::REG_IDX_W-1:0] idx,
			input logic [mme_pkg::PDATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mme_pkg::REG_ROWS_A: cfg_rows = clamp_size(val[mme_pkg::CFG_W-1:0]);
			mme_pkg::REG_INNER_LEN: cfg_inner = clamp_size(val[mme_pkg::CFG_W-1:0]);
			mme_pkg::REG_COLS_B: cfg_cols = clamp_size(val[mme_pkg::CFG_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic set_sizes(input int rows, input int inner, input int cols);
		apb_write(mme_pkg::REG_ROWS_A, rows);
		apb_write(mme_pkg::REG_INNER_LEN, inner);
		apb_write(mme_pkg::REG_COLS_B, cols);
	endtask

	// Let the engine drain everything it holds, loads included.
	task automatic wait_idle();
		while (pending.size() != 0 || word_loaded || in_valid || product_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Queue one word and note which store entries it fills.
	task automatic push_word(input logic [1:0] k, input int r, input int c,
			input logic [mme_pkg::VAL_W-1:0] v, input bit hold);
		word_t w;
		w.kind = k;
		w.row = r[mme_pkg::IDX_W-1:0];
		w.col = c[mme_pkg::IDX_W-1:0];
		w.value = v;
		w.hold = hold;
		pending.push_back(w);
		words_counted++;
		case (k)
			mme_pkg::KIND_LOAD_A: begin
				if (r < cfg_rows && c < cfg_inner)
					a_set[r*DIM_MAX + c] = 1'b1;
			end
			mme_pkg::KIND_LOAD_B: begin
				if (r < cfg_inner && c < cfg_cols)
					b_set[r*DIM_MAX + c] = 1'b1;
			end
			default: ;
		endcase
	endtask

	// A request preceded by loads of any A row or B column entry still empty.
	task automatic push_request(input int r, input int c);
		if (r < cfg_rows && c < cfg_cols) begin
			for (int i = 0; i < cfg_inner; i++) begin
				if (!a_set[r*DIM_MAX + i])
					push_word(mme_pkg::KIND_LOAD_A, r, i, draw_value(), 1'b0);
				if (!b_set[i*DIM_MAX + c])
					push_word(mme_pkg::KIND_LOAD_B, i, c, draw_value(), 1'b0);
			end
		end
		push_word(mme_pkg::KIND_REQUEST, r, c, rand_value(), $urandom_range(0, 99) == 0);
	endtask

	// One random phase under one set of sizes.
	task automatic run_phase(input int rows, input int inner, input int cols, input int quota);
		int stop_at;
		int pick;
		logic [1:0] k;
		wait_idle();
		set_sizes(rows, inner, cols);
		@(posedge clk);
		stop_at = words_counted + quota;
		while (words_counted < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if (cfg_rows > 0 && cfg_cols > 0)
					push_request(pick_below(cfg_rows), pick_below(cfg_cols));
				else
					push_request(pick_below(DIM_MAX), pick_below(DIM_MAX));
			end else if (pick < 75) begin
				if ($urandom_range(0, 1)) begin
					if (cfg_rows > 0 && cfg_inner > 0)
						push_word(mme_pkg::KIND_LOAD_A, pick_below(cfg_rows),
							pick_below(cfg_inner), draw_value(), $urandom_range(0, 99) == 0);
				end else if (cfg_inner > 0 && cfg_cols > 0) begin
					push_word(mme_pkg::KIND_LOAD_B, pick_below(cfg_inner), pick_below(cfg_cols),
						draw_value(), $urandom_range(0, 99) == 0);
				end
			end else begin
				// Noise over the whole field ranges, out-of-range words included.
				k = 2'($urandom_range(0, 3));
				if (k == mme_pkg::KIND_REQUEST)
					push_request(pick_below(DIM_MAX), pick_below(DIM_MAX));
				else
					push_word(k, pick_below(DIM_MAX), pick_below(DIM_MAX), rand_value(),
						$urandom_range(0, 99) == 0);
			end
		end
	endtask

	// Input driver: present the next word after its drawn wait; a held word also waits until no product is due.
	always @(negedge clk) begin
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && word_taken) begin
				next_valid = 1'b0;
				word_taken = 1'b0;
			end
			if (!next_valid) begin
				if (!word_loaded && pending.size() > 0) begin
					cur_word = pending.pop_front();
					word_loaded = 1'b1;
					in_wait = draw_wait(0);
				end
				if (word_loaded) begin
					if (in_wait > 0) begin
						in_wait--;
					end else if (!cur_word.hold || product_due.size() == 0) begin
						kind <= cur_word.kind;
						row_index <= cur_word.row;
						col_index <= cur_word.col;
						element_value <= cur_word.value;
						next_valid = 1'b1;
						word_loaded = 1'b0;
					end
				end
			end
			in_valid <= next_valid;
		end
	end

	// Output stall: a fresh wait after each taken result, spent while valid is high.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				result_taken = 1'b0;
				out_wait = draw_wait(1);
			end else if (out_valid && out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait > 0);
		end
	end

	// Monitor: feed accepted input words to the predictor, check result words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_word(kind, row_index, col_index, element_value);
				word_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				result_taken = 1'b1;
				if (product_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: row %0d col %0d value %0d",
							out_row, out_col, product_value);
				end else if (out_row !== product_due[0].row || out_col !== product_due[0].col
						|| product_value !== product_due[0].value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected (%0d,%0d) %0d, got (%0d,%0d) %0d",
							product_due[0].row, product_due[0].col, product_due[0].value,
							out_row, out_col, product_value);
					void'(product_due.pop_front());
				end else begin
					void'(product_due.pop_front());
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Loads at the far corner under the reset sizes.
		push_word(mme_pkg::KIND_LOAD_A, 63, 63, 16'h7fff, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 63, 63, 16'h8000, 1'b0);
		wait_idle();

		// Directed words: extremes, dropped loads and requests, the unused kind.
		set_sizes(3, 2, 3);
		@(posedge clk);
		push_word(mme_pkg::KIND_LOAD_A, 0, 0, 16'h8000, 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 0, 1, 16'h8000, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 0, 0, 16'h8000, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 1, 0, 16'h8000, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 0, 0, 16'h0000, 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 1, 0, 16'h7fff, 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 1, 1, 16'h8000, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 0, 1, 16'h7fff, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 1, 1, 16'h7fff, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 1, 1, 16'h0000, 1'b1);
		push_word(mme_pkg::KIND_REQUEST, 0, 1, 16'h0000, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 1, 0, 16'hffff, 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 3, 0, 16'h1234, 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 0, 2, 16'h1234, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 2, 0, 16'h1234, 1'b0);
		push_word(mme_pkg::KIND_LOAD_B, 0, 3, 16'h1234, 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 63, 63, 16'hffff, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 3, 0, 16'h0000, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 0, 3, 16'h0000, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 63, 63, 16'h0000, 1'b0);
		push_word(KIND_UNUSED, 1, 1, rand_value(), 1'b0);
		push_word(mme_pkg::KIND_LOAD_A, 2, 0, 16'h0000, 1'b0);
		push_request(2, 2);
		push_word(mme_pkg::KIND_REQUEST, 0, 0, 16'h0000, 1'b0);
		wait_idle();

		// A write past the last register must leave the sizes alone.
		apb_write(REG_SPARE, 1);
		@(posedge clk);
		push_word(mme_pkg::KIND_REQUEST, 0, 0, 16'h0000, 1'b0);
		push_word(mme_pkg::KIND_REQUEST, 1, 1, 16'h0000, 1'b0);

		run_phase(4, 8, 5, 250);
		run_phase(1, 1, 1, 60);
		run_phase(2, 64, 3, 300);
		run_phase(127, 2, 127, 250);
		run_phase(0, 5, 3, 40);
		run_phase(3, 0, 4, 40);
		run_phase(5, 3, 0, 40);

		// Largest possible sum: a full-length dot product of the most negative value.
		wait_idle();
		set_sizes(1, 64, 1);
		@(posedge clk);
		for (int i = 0; i < DIM_MAX; i++) begin
			push_word(mme_pkg::KIND_LOAD_A, 0, i, 16'h8000, 1'b0);
			push_word(mme_pkg::KIND_LOAD_B, i, 0, 16'h8000, 1'b0);
		end
		push_word(mme_pkg::KIND_REQUEST, 0, 0, 16'h0000, 1'b0);

		run_phase(7, 13, 6, 300);
		run_phase(64, 1, 100, 150);
		run_phase(3, 5, 2, 60);
		wait_idle();

		if (mismatches == 0 && product_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mme_pkg.sv
hdl/mme_ram.sv
hdl/mme_front.sv
hdl/mme_queue.sv
hdl/mme_back.sv
hdl/matrix_multiply_engine.sv
sim/testbench.sv
